[hw/rtl/tfn_pkg.sv]
// Package for the triangle face normal unit: widths, lane types and stage counts.
// Used by triangle_face_normal_unit; depends on nothing.
`default_nettype none
package tfn_pkg;
  localparam int CW = 16;
  localparam int EW = 17;
  localparam int PW = 34;
  localparam int NW = 35;
  localparam int MW = 34;
  localparam int QW = 68;
  localparam int SW = 70;
  localparam int LW = 98;
  localparam int TW = 102;
  localparam int KW = 14;
  localparam int RW = 15;
  localparam int SRCH = KW + 1;
  localparam int LAT = 6 + SRCH;

  typedef logic signed [EW-1:0] edge_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic [TW-1:0] wide_t;
endpackage
`default_nettype wire

[hw/rtl/triangle_face_normal_unit.sv]
// Triangle unit face normal, fully pipelined: edges, cross product, squared
// length and a bit-per-stage rounding search. Depends on tfn_pkg.
//
//   channel | ports                         | handshake
//   input   | in_a_x .. in_c_z              | start high and busy low
//   result  | out_norm_x/y/z, out_degenerate| out_valid strobe, one cycle
//
// One item may enter every cycle; busy is always low.
// Each result passes five arithmetic stages, then 15 search stages (the first
// sets up the search; each later one resolves one quotient bit), then an output register.
// Reset clears only the valid bits; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module triangle_face_normal_unit
  import tfn_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [CW-1:0] in_a_x,
  input  wire logic signed [CW-1:0] in_a_y,
  input  wire logic signed [CW-1:0] in_a_z,
  input  wire logic signed [CW-1:0] in_b_x,
  input  wire logic signed [CW-1:0] in_b_y,
  input  wire logic signed [CW-1:0] in_b_z,
  input  wire logic signed [CW-1:0] in_c_x,
  input  wire logic signed [CW-1:0] in_c_y,
  input  wire logic signed [CW-1:0] in_c_z,
  output logic                      out_valid,
  output logic signed [CW-1:0]      out_norm_x,
  output logic signed [CW-1:0]      out_norm_y,
  output logic signed [CW-1:0]      out_norm_z,
  output logic                      out_degenerate
);

  logic [LAT-1:0] vld_r;
  edge_t e1_r [3];
  edge_t e2_r [3];
  prod_t pa_r [3];
  prod_t pb_r [3];
  logic [MW-1:0] m_r [3];
  logic [2:0] neg3_r;
  logic [QW-1:0] q_r [3];
  logic [2:0] neg4_r;
  logic [SW-1:0] s_r;
  logic [LW-1:0] l_r [3];
  logic [2:0] neg5_r;

  wide_t sp_r [SRCH];
  wide_t lp_r [3][SRCH];
  wide_t t_r [3][SRCH];
  wide_t u_r [3][SRCH];
  logic [KW-1:0] k_r [3][SRCH];
  logic [2:0] ok_r [SRCH];
  logic [2:0] negp_r [SRCH];
  logic degp_r [SRCH];

  wide_t t_nxt [3][SRCH];
  wide_t u_nxt [3][SRCH];
  logic [KW-1:0] k_nxt [3][SRCH];
  logic [2:0] ok_nxt [SRCH];
  logic signed [CW-1:0] nrm_nxt [3];

  logic signed [CW-1:0] nrm_r [3];
  logic deg_r;

  logic signed [NW-1:0] n_w [3];
  logic [RW-1:0] r_w [3];

  assign busy = 1'b0;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      n_w[l] = NW'(pa_r[l]) - NW'(pb_r[l]);
    end
  end

  always_comb begin
    wide_t cand;
    cand = '0;
    for (int l = 0; l < 3; l++) begin
      for (int p = 0; p < SRCH; p++) begin
        t_nxt[l][p] = t_r[l][p];
        u_nxt[l][p] = u_r[l][p];
        k_nxt[l][p] = k_r[l][p];
        ok_nxt[p][l] = ok_r[p][l];
        if (p > 0) begin
          cand = t_r[l][p] + (u_r[l][p] << (KW - p + 2)) + (sp_r[p] << (2 * (KW - p) + 2));
          if (ok_r[p][l] && cand <= lp_r[l][p]) begin
            t_nxt[l][p] = cand;
            u_nxt[l][p] = u_r[l][p] + (sp_r[p] << (KW - p + 1));
            k_nxt[l][p] = k_r[l][p] | (KW'(1) << (KW - p));
          end
        end
      end
      r_w[l] = ok_nxt[SRCH-1][l] ? RW'(k_nxt[l][SRCH-1]) + RW'(1) : '0;
      if (degp_r[SRCH-1]) begin
        nrm_nxt[l] = '0;
      end else if (negp_r[SRCH-1][l]) begin
        nrm_nxt[l] = -$signed({1'b0, r_w[l]});
      end else begin
        nrm_nxt[l] = $signed({1'b0, r_w[l]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end

    e1_r[0] <= EW'(in_b_x) - EW'(in_a_x);
    e1_r[1] <= EW'(in_b_y) - EW'(in_a_y);
    e1_r[2] <= EW'(in_b_z) - EW'(in_a_z);
    e2_r[0] <= EW'(in_c_x) - EW'(in_a_x);
    e2_r[1] <= EW'(in_c_y) - EW'(in_a_y);
    e2_r[2] <= EW'(in_c_z) - EW'(in_a_z);

    pa_r[0] <= e2_r[1] * e1_r[2];
    pb_r[0] <= e2_r[2] * e1_r[1];
    pa_r[1] <= e2_r[2] * e1_r[0];
    pb_r[1] <= e2_r[0] * e1_r[2];
    pa_r[2] <= e2_r[0] * e1_r[1];
    pb_r[2] <= e2_r[1] * e1_r[0];

    for (int l = 0; l < 3; l++) begin
      neg3_r[l] <= n_w[l][NW-1];
      m_r[l] <= n_w[l][NW-1] ? MW'(-n_w[l]) : MW'(n_w[l]);
      q_r[l] <= QW'(m_r[l]) * QW'(m_r[l]);
      l_r[l] <= LW'(q_r[l]) << 30;
    end
    neg4_r <= neg3_r;
    neg5_r <= neg4_r;
    s_r <= SW'(q_r[0]) + SW'(q_r[1]) + SW'(q_r[2]);

    sp_r[0] <= TW'(s_r);
    degp_r[0] <= (s_r == '0);
    negp_r[0] <= neg5_r;
    for (int l = 0; l < 3; l++) begin
      lp_r[l][0] <= TW'(l_r[l]);
      t_r[l][0] <= TW'(s_r);
      u_r[l][0] <= TW'(s_r);
      k_r[l][0] <= '0;
      ok_r[0][l] <= (TW'(s_r) <= TW'(l_r[l]));
    end
    for (int p = 1; p < SRCH; p++) begin
      sp_r[p] <= sp_r[p-1];
      degp_r[p] <= degp_r[p-1];
      negp_r[p] <= negp_r[p-1];
      ok_r[p] <= ok_nxt[p-1];
      for (int l = 0; l < 3; l++) begin
        lp_r[l][p] <= lp_r[l][p-1];
        t_r[l][p] <= t_nxt[l][p-1];
        u_r[l][p] <= u_nxt[l][p-1];
        k_r[l][p] <= k_nxt[l][p-1];
      end
    end

    for (int l = 0; l < 3; l++) begin
      nrm_r[l] <= nrm_nxt[l];
    end
    deg_r <= degp_r[SRCH-1];
  end

  assign out_valid = vld_r[LAT-1];
  assign out_norm_x = nrm_r[0];
  assign out_norm_y = nrm_r[1];
  assign out_norm_z = nrm_r[2];
  assign out_degenerate = deg_r;

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_norm_x == 0 && out_norm_y == 0 && out_norm_z == 0)
    else $error("degenerate result is not the zero vector");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(vld_r[LAT-2]) |-> out_valid)
    else $error("item lost in the pipeline");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_norm_x <= 16384 && out_norm_x >= -16384 &&
                  out_norm_y <= 16384 && out_norm_y >= -16384 &&
                  out_norm_z <= 16384 && out_norm_z >= -16384)
    else $error("normal component out of range");

endmodule
`default_nettype wire
